// ----- design/deq_pkg.sv -----
// deq_pkg: shared constants, codes and control structs of the double-ended queue
// no dependencies; used by the interfaces, deq_ctrl, deq_dp, the top level and the bench

package deq_pkg;

    // default sizing of the ring store
    localparam int DEPTH_DEF       = 256;
    localparam int VALUE_WIDTH_DEF = 32;

    // fixed field widths on the channels
    localparam int KIND_W   = 2;
    localparam int VALUE_W  = 32;
    localparam int STATUS_W = 2;
    localparam int OCC_W    = 9;

    // operation codes
    localparam logic [KIND_W-1:0] KIND_PUSH_FRONT = 2'd0;
    localparam logic [KIND_W-1:0] KIND_PUSH_BACK  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_POP_FRONT  = 2'd2;
    localparam logic [KIND_W-1:0] KIND_POP_BACK   = 2'd3;

    // result status codes
    localparam logic [STATUS_W-1:0] STAT_DONE  = 2'd0;
    localparam logic [STATUS_W-1:0] STAT_EMPTY = 2'd1;
    localparam logic [STATUS_W-1:0] STAT_FULL  = 2'd2;

    // controller to datapath
    typedef struct packed {
        logic accept;     // item taken this cycle
        logic load_read;  // store read data is valid, finish the pop
    } t_dp_cmd;

    // datapath to controller
    typedef struct packed {
        logic read_needed;  // current item is a pop on a non-empty queue
        logic out_free;     // result register empty or drained this cycle
    } t_dp_sts;

endpackage

// ----- design/deq_if.sv -----
// deq_if: request and response channel interfaces of the double-ended queue
// depends on deq_pkg for field widths

interface deq_req_if;
    logic                          valid;
    logic                          ready;
    logic [deq_pkg::KIND_W-1:0]    kind;
    logic [deq_pkg::VALUE_W-1:0]   push_value;

    modport source (output valid, output kind, output push_value, input ready);
    modport sink   (input valid, input kind, input push_value, output ready);
endinterface

interface deq_rsp_if;
    logic                          valid;
    logic                          ready;
    logic [deq_pkg::VALUE_W-1:0]   popped_value;
    logic [deq_pkg::STATUS_W-1:0]  status;
    logic [deq_pkg::OCC_W-1:0]     occupancy;

    modport source (output valid, output popped_value, output status, output occupancy,
                    input ready);
    modport sink   (input valid, input popped_value, input status, input occupancy,
                    output ready);
endinterface

// ----- design/deq_ram.sv -----
// deq_ram: generic simple dual-port RAM, one write and one registered read port
// no dependencies

module deq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- design/deq_ctrl.sv -----
// deq_ctrl: controller state machine, accepts items and sequences the store read of a pop
// depends on deq_pkg for the command and status structs

module deq_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_req_valid,
    input  deq_pkg::t_dp_sts i_sts,
    output logic             o_req_ready,
    output deq_pkg::t_dp_cmd o_cmd
);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_READ = 1'b1;

    logic r_state;
    logic n_state;
    logic accept;

    assign o_req_ready = (r_state == ST_IDLE) && i_sts.out_free;
    assign accept      = i_req_valid && o_req_ready;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (accept && i_sts.read_needed) begin
                    n_state = ST_READ;
                end
            end
            ST_READ: begin
                n_state = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_cmd.accept    = accept;
    assign o_cmd.load_read = (r_state == ST_READ);

endmodule

// ----- design/deq_dp.sv -----
// deq_dp: datapath with front index, entry count, ring store and result register
// depends on deq_pkg and deq_ram

module deq_dp #(
    parameter int DEPTH       = deq_pkg::DEPTH_DEF,
    parameter int VALUE_WIDTH = deq_pkg::VALUE_WIDTH_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic [deq_pkg::KIND_W-1:0]      i_kind,
    input  logic [deq_pkg::VALUE_W-1:0]     i_push_value,
    input  logic                            i_rsp_ready,
    input  deq_pkg::t_dp_cmd                i_cmd,
    output deq_pkg::t_dp_sts                o_sts,
    output logic                            o_rsp_valid,
    output logic [deq_pkg::VALUE_W-1:0]     o_popped_value,
    output logic [deq_pkg::STATUS_W-1:0]    o_status,
    output logic [deq_pkg::OCC_W-1:0]       o_occupancy
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    logic [AW-1:0] r_front;
    logic [AW-1:0] n_front;
    logic [CW-1:0] r_count;
    logic [CW-1:0] n_count;

    logic                          r_out_valid;
    logic [deq_pkg::VALUE_W-1:0]   r_out_value;
    logic [deq_pkg::STATUS_W-1:0]  r_out_status;
    logic [deq_pkg::OCC_W-1:0]     r_out_occ;

    logic                          full;
    logic                          empty;
    logic [AW-1:0]                 front_dec;
    logic [AW-1:0]                 front_inc;
    logic [CW:0]                   back_sum;
    logic [CW:0]                   last_sum;
    logic [AW-1:0]                 back_slot;
    logic [AW-1:0]                 last_slot;

    logic                          we;
    logic [AW-1:0]                 waddr;
    logic                          re;
    logic [AW-1:0]                 raddr;
    logic                          read_needed;
    logic [deq_pkg::STATUS_W-1:0]  imm_status;
    logic [VALUE_WIDTH-1:0]        rdata;

    assign full  = (r_count == CW'(DEPTH));
    assign empty = (r_count == '0);

    // ring arithmetic, works for any depth of two or more
    assign front_dec = (r_front == '0) ? AW'(DEPTH - 1) : r_front - AW'(1);
    assign front_inc = (r_front == AW'(DEPTH - 1)) ? '0 : r_front + AW'(1);
    assign back_sum  = (CW + 1)'(r_front) + (CW + 1)'(r_count);
    assign last_sum  = back_sum - (CW + 1)'(1);
    assign back_slot = (back_sum >= (CW + 1)'(DEPTH)) ?
                       AW'(back_sum - (CW + 1)'(DEPTH)) : AW'(back_sum);
    assign last_slot = (last_sum >= (CW + 1)'(DEPTH)) ?
                       AW'(last_sum - (CW + 1)'(DEPTH)) : AW'(last_sum);

    always_comb begin
        n_front     = r_front;
        n_count     = r_count;
        we          = 1'b0;
        waddr       = r_front;
        re          = 1'b0;
        raddr       = r_front;
        read_needed = 1'b0;
        imm_status  = deq_pkg::STAT_DONE;
        unique case (i_kind)
            deq_pkg::KIND_PUSH_FRONT: begin
                if (full) begin
                    imm_status = deq_pkg::STAT_FULL;
                end else begin
                    we      = 1'b1;
                    waddr   = front_dec;
                    n_front = front_dec;
                    n_count = r_count + CW'(1);
                end
            end
            deq_pkg::KIND_PUSH_BACK: begin
                if (full) begin
                    imm_status = deq_pkg::STAT_FULL;
                end else begin
                    we      = 1'b1;
                    waddr   = back_slot;
                    n_count = r_count + CW'(1);
                end
            end
            deq_pkg::KIND_POP_FRONT: begin
                if (empty) begin
                    imm_status = deq_pkg::STAT_EMPTY;
                end else begin
                    re          = 1'b1;
                    read_needed = 1'b1;
                    raddr       = r_front;
                    n_front     = front_inc;
                    n_count     = r_count - CW'(1);
                end
            end
            deq_pkg::KIND_POP_BACK: begin
                if (empty) begin
                    imm_status = deq_pkg::STAT_EMPTY;
                end else begin
                    re          = 1'b1;
                    read_needed = 1'b1;
                    raddr       = last_slot;
                    n_count     = r_count - CW'(1);
                end
            end
        endcase
    end

    deq_ram #(
        .WIDTH (VALUE_WIDTH),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (we && i_cmd.accept),
        .i_waddr (waddr),
        .i_wdata (VALUE_WIDTH'(i_push_value)),
        .i_re    (re && i_cmd.accept),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    // pointer state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_front <= '0;
            r_count <= '0;
        end else if (i_cmd.accept) begin
            r_front <= n_front;
            r_count <= n_count;
        end
    end

    // result register: set at accept for pushes and misses, for a hitting pop when the store read data is loaded
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if ((i_cmd.accept && !read_needed) || i_cmd.load_read) begin
            r_out_valid <= 1'b1;
        end else if (i_rsp_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_out_value  <= '0;
            r_out_status <= imm_status;
            r_out_occ    <= deq_pkg::OCC_W'(n_count);
        end else if (i_cmd.load_read) begin
            r_out_value  <= deq_pkg::VALUE_W'(rdata);
        end
    end

    assign o_sts.read_needed = read_needed;
    assign o_sts.out_free    = !r_out_valid || i_rsp_ready;

    assign o_rsp_valid    = r_out_valid;
    assign o_popped_value = r_out_value;
    assign o_status       = r_out_status;
    assign o_occupancy    = r_out_occ;

endmodule

// ----- design/double_ended_queue.sv -----
// double_ended_queue: top level of the bounded double-ended queue
// depends on deq_pkg, deq_if, deq_ctrl, deq_dp and deq_ram
//
// usage
//   i_req carries one item per operation: kind (push front, push back,
//   pop front, pop back) and push_value, which pops ignore. o_rsp returns
//   exactly one item per request: popped_value, status and occupancy after
//   the operation. a pop on an empty queue gives 0 with the empty status,
//   a push on a full queue is dropped and flagged full.
//   pushes and misses are registered into the result register at accept;
//   a pop that hits first reads the registered read port of the ring
//   store, and its result is loaded from the read data in the read state.
//   throughput: one push or miss per cycle while o_rsp is ready; a hitting
//   pop blocks the next item until its store read completes.
//   a single result register parts the two sides; i_req.ready is high
//   when no pop read is in flight and that register is empty or being
//   drained, so a stalled receiver holds at most one finished item and
//   then stalls the sender.
//   reset (synchronous, active low) empties the queue: front index and
//   count go to zero and no result is pending. store contents are not
//   cleared, no entry is read before it is written.

module double_ended_queue #(
    parameter int DEPTH       = deq_pkg::DEPTH_DEF,
    parameter int VALUE_WIDTH = deq_pkg::VALUE_WIDTH_DEF
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    deq_req_if.sink  i_req,
    deq_rsp_if.source o_rsp
);

    deq_pkg::t_dp_cmd cmd;
    deq_pkg::t_dp_sts sts;

    // controller: accept and pop read sequencing
    deq_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req.valid),
        .i_sts       (sts),
        .o_req_ready (i_req.ready),
        .o_cmd       (cmd)
    );

    // datapath: ring pointers, store and result register
    deq_dp #(
        .DEPTH       (DEPTH),
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_kind         (i_req.kind),
        .i_push_value   (i_req.push_value),
        .i_rsp_ready    (o_rsp.ready),
        .i_cmd          (cmd),
        .o_sts          (sts),
        .o_rsp_valid    (o_rsp.valid),
        .o_popped_value (o_rsp.popped_value),
        .o_status       (o_rsp.status),
        .o_occupancy    (o_rsp.occupancy)
    );

    // a hitting pop blocks the next item while the store read completes
    a_pop_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (cmd.accept && sts.read_needed) |=> !i_req.ready)
        else $error("item accepted during pop read");

    // a full status only when the queue holds every entry
    a_full_occ: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp.valid && o_rsp.status == deq_pkg::STAT_FULL)
        |-> (o_rsp.occupancy == deq_pkg::OCC_W'(DEPTH)))
        else $error("full status with queue not full");

    // an empty status only with nothing held, and then no value
    a_empty_occ: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp.valid && o_rsp.status == deq_pkg::STAT_EMPTY)
        |-> (o_rsp.occupancy == '0 && o_rsp.popped_value == '0))
        else $error("empty status with entries held");

    // the result register never reports a load while the pop read is still pending
    a_no_early_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (cmd.accept && sts.read_needed) |=> (!o_rsp.valid && cmd.load_read))
        else $error("pop result shown before store read");

endmodule

// ----- bench/tb_double_ended_queue.sv -----
`timescale 1ns / 1ps
// tb_double_ended_queue: self-checking bench for the bounded double-ended queue
// depends on deq_pkg, deq_if and double_ended_queue; drives a table then random traffic

module tb_double_ended_queue;
    import deq_pkg::*;

    // ring size and slot index width of the mirrored queue
    localparam int RING_DEPTH  = DEPTH_DEF;
    localparam int IDX_W       = $clog2(RING_DEPTH);
    // long receiver hold-off, counted by the receiver process
    localparam int HOLD_CYCLES = 200;
    // watchdog, far above the slowest legal run
    localparam int CYCLE_LIMIT = 200000;
    // bound on the final drain of outstanding results
    localparam int DRAIN_LIMIT = 2000;

    // one result item as the block reports it
    typedef struct packed {
        logic [VALUE_W-1:0]  popped;
        logic [STATUS_W-1:0] status;
        logic [OCC_W-1:0]    occupancy;
    } t_deq_result;

    // one row of the directed table; fixed marks a result typed in by hand
    typedef struct packed {
        logic [KIND_W-1:0]   kind;
        logic [VALUE_W-1:0]  value;
        logic                fixed;
        logic [VALUE_W-1:0]  popped;
        logic [STATUS_W-1:0] status;
        logic [OCC_W-1:0]    occupancy;
    } t_stim_row;

    // directed part: empty pops, extreme values, both ends, ring wrap on push front
    localparam t_stim_row STIM_TABLE [0:18] = '{
        '{KIND_POP_FRONT,  32'h0000_0000, 1'b1, 32'h0000_0000, STAT_EMPTY, 9'd0},
        '{KIND_POP_BACK,   32'hFFFF_FFFF, 1'b1, 32'h0000_0000, STAT_EMPTY, 9'd0},
        '{KIND_PUSH_FRONT, 32'hFFFF_FFFF, 1'b1, 32'h0000_0000, STAT_DONE,  9'd1},
        '{KIND_POP_BACK,   32'h0000_0000, 1'b1, 32'hFFFF_FFFF, STAT_DONE,  9'd0},
        '{KIND_PUSH_BACK,  32'h0000_0000, 1'b1, 32'h0000_0000, STAT_DONE,  9'd1},
        '{KIND_POP_FRONT,  32'hFFFF_FFFF, 1'b1, 32'h0000_0000, STAT_DONE,  9'd0},
        '{KIND_PUSH_BACK,  32'h0000_0001, 1'b0, 32'h0, STAT_DONE, 9'd0},
        '{KIND_PUSH_FRONT, 32'h8000_0000, 1'b0, 32'h0, STAT_DONE, 9'd0},
        '{KIND_PUSH_BACK,  32'hAAAA_AAAA, 1'b0, 32'h0, STAT_DONE, 9'd0},
        '{KIND_PUSH_FRONT, 32'h5555_5555, 1'b0, 32'h0, STAT_DONE, 9'd0},
        '{KIND_POP_FRONT,  32'h0000_0000, 1'b0, 32'h0, STAT_DONE, 9'd0},
        '{KIND_POP_BACK,   32'h0000_0000, 1'b0, 32'h0, STAT_DONE, 9'd0},
        '{KIND_POP_BACK,   32'hFFFF_FFFF, 1'b0, 32'h0, STAT_DONE, 9'd0},
        '{KIND_POP_FRONT,  32'h0000_0000, 1'b0, 32'h0, STAT_DONE, 9'd0},
        '{KIND_POP_BACK,   32'h0000_0000, 1'b1, 32'h0000_0000, STAT_EMPTY, 9'd0},
        '{KIND_PUSH_BACK,  32'h7FFF_FFFF, 1'b0, 32'h0, STAT_DONE, 9'd0},
        '{KIND_PUSH_FRONT, 32'hFFFF_FFFE, 1'b0, 32'h0, STAT_DONE, 9'd0},
        '{KIND_POP_FRONT,  32'h0000_0000, 1'b0, 32'h0, STAT_DONE, 9'd0},
        '{KIND_POP_FRONT,  32'h0000_0000, 1'b0, 32'h0, STAT_DONE, 9'd0}
    };

    logic i_clk = 1'b0;
    logic i_rst_n;

    deq_req_if req_ch ();
    deq_rsp_if rsp_ch ();

    double_ended_queue i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch.sink),
        .o_rsp   (rsp_ch.source)
    );

    // 20 ns period
    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // mirror of the queue state
    logic [VALUE_W-1:0] ring_mirror [RING_DEPTH];
    logic [IDX_W-1:0]   mirror_front;
    logic [OCC_W-1:0]   mirror_count;

    // results owed by the block, oldest first
    t_deq_result pending_results [$];

    int err_count   = 0;
    int cycle_count = 0;
    int full_hits   = 0;   // pushes dropped on a full queue so far
    int empty_hits  = 0;   // pops on an empty queue so far

    // idle odds in percent, set by the stimulus process
    int src_idle_pct  = 0;
    int sink_idle_pct = 0;
    // bumped by the stimulus process to start one receiver hold-off
    int hold_asked    = 0;

    // apply one operation to the mirror and return what the block must report
    function automatic t_deq_result deque_apply(input logic [KIND_W-1:0] kind,
                                                input logic [VALUE_W-1:0] value);
        t_deq_result      res;
        logic [IDX_W-1:0] slot;
        res.popped = '0;
        res.status = STAT_DONE;
        if (kind == KIND_PUSH_FRONT || kind == KIND_PUSH_BACK) begin
            if (mirror_count == OCC_W'(RING_DEPTH)) begin
                // full: value dropped, state untouched
                res.status = STAT_FULL;
                full_hits++;
            end else if (kind == KIND_PUSH_FRONT) begin
                // front steps back one slot, wraps through the index width
                mirror_front = mirror_front - 1'b1;
                ring_mirror[mirror_front] = value;
                mirror_count = mirror_count + 1'b1;
            end else begin
                slot = mirror_front + mirror_count[IDX_W-1:0];
                ring_mirror[slot] = value;
                mirror_count = mirror_count + 1'b1;
            end
        end else begin
            if (mirror_count == '0) begin
                res.status = STAT_EMPTY;
                empty_hits++;
            end else if (kind == KIND_POP_FRONT) begin
                res.popped   = ring_mirror[mirror_front];
                mirror_front = mirror_front + 1'b1;
                mirror_count = mirror_count - 1'b1;
            end else begin
                slot = mirror_front + mirror_count[IDX_W-1:0] - 1'b1;
                res.popped   = ring_mirror[slot];
                mirror_count = mirror_count - 1'b1;
            end
        end
        res.occupancy = mirror_count;
        return res;
    endfunction

    // offer one item from a falling edge until taken; returns at a falling edge
    task automatic send_item(input logic [KIND_W-1:0] kind, input logic [VALUE_W-1:0] value,
                             input logic fixed, input t_deq_result fixed_result);
        t_deq_result model_result;
        // random sender gaps, with junk on the payload while valid is low
        while ($urandom_range(0, 99) < src_idle_pct) begin
            req_ch.valid      = 1'b0;
            req_ch.kind       = KIND_W'($urandom_range(0, 3));
            req_ch.push_value = $urandom;
            @(negedge i_clk);
        end
        req_ch.valid      = 1'b1;
        req_ch.kind       = kind;
        req_ch.push_value = value;
        // ready is sampled at the rising edge, before the block updates
        do begin
            @(posedge i_clk);
        end while (req_ch.ready !== 1'b1);
        model_result = deque_apply(kind, value);
        // hand-typed rows are checked against their own numbers
        pending_results.push_back(fixed ? fixed_result : model_result);
        @(negedge i_clk);
    endtask

    // random traffic: runs at least min_items and at most 800, and on until the wanted number of
    // new full and empty hits has been seen; push_pct sets the odds of a push in percent
    task automatic run_random(input int min_items, input int push_pct,
                              input int full_goal, input int empty_goal);
        int                 sent;
        int                 full_base;
        int                 empty_base;
        logic [KIND_W-1:0]  kind;
        logic [VALUE_W-1:0] value;
        t_deq_result        unused;
        sent       = 0;
        full_base  = full_hits;
        empty_base = empty_hits;
        unused     = '0;
        while (sent < 800 && (sent < min_items || full_hits - full_base < full_goal
                                               || empty_hits - empty_base < empty_goal)) begin
            if ($urandom_range(0, 99) < push_pct)
                kind = $urandom_range(0, 1) ? KIND_PUSH_BACK : KIND_PUSH_FRONT;
            else
                kind = $urandom_range(0, 1) ? KIND_POP_BACK : KIND_POP_FRONT;
            // extremes now and then, plain random words otherwise
            case ($urandom_range(0, 7))
                0: value = '0;
                1: value = '1;
                default: value = $urandom;
            endcase
            send_item(kind, value, 1'b0, unused);
            sent++;
        end
    endtask

    // receiver: random stalls, plus one long hold-off counted here
    initial begin : sink_side
        int hold_left;
        int hold_seen;
        hold_left    = 0;
        hold_seen    = 0;
        rsp_ch.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_asked != hold_seen) begin
                hold_seen = hold_asked;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                rsp_ch.ready = 1'b0;
                hold_left--;
            end else begin
                rsp_ch.ready = ($urandom_range(0, 99) >= sink_idle_pct);
            end
        end
    end

    // compare every taken result with the oldest one owed
    always @(posedge i_clk) begin : result_check
        t_deq_result want;
        if (i_rst_n === 1'b1 && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
            if (pending_results.size() == 0) begin
                $error("result item with none outstanding: popped_value %h status %0d occupancy %0d",
                       rsp_ch.popped_value, rsp_ch.status, rsp_ch.occupancy);
                err_count++;
            end else begin
                want = pending_results.pop_front();
                if (rsp_ch.popped_value !== want.popped) begin
                    $error("popped_value: expected %h, got %h", want.popped, rsp_ch.popped_value);
                    err_count++;
                end
                if (rsp_ch.status !== want.status) begin
                    $error("status: expected %0d, got %0d", want.status, rsp_ch.status);
                    err_count++;
                end
                if (rsp_ch.occupancy !== want.occupancy) begin
                    $error("occupancy: expected %0d, got %0d", want.occupancy, rsp_ch.occupancy);
                    err_count++;
                end
            end
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("tb_double_ended_queue: done, errors");
            $finish;
        end
    end

    initial begin : source_side
        t_deq_result fixed_exp;
        int          drain_cycles;
        // quiet inputs and reset from time zero
        i_rst_n           = 1'b0;
        req_ch.valid      = 1'b0;
        req_ch.kind       = KIND_PUSH_FRONT;
        req_ch.push_value = '0;
        mirror_front      = '0;
        mirror_count      = '0;
        // first idling mode: slow receiver
        src_idle_pct  = 24;
        sink_idle_pct = 73;
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed table
        for (int r = 0; r < $size(STIM_TABLE); r++) begin
            fixed_exp.popped    = STIM_TABLE[r].popped;
            fixed_exp.status    = STIM_TABLE[r].status;
            fixed_exp.occupancy = STIM_TABLE[r].occupancy;
            send_item(STIM_TABLE[r].kind, STIM_TABLE[r].value, STIM_TABLE[r].fixed, fixed_exp);
        end

        // mixed traffic, then fill past full, then drain past empty
        run_random(120, 55, 0, 0);
        run_random(0, 92, 10, 0);
        run_random(0, 8, 0, 10);

        // sender pauses until every owed result is back
        req_ch.valid = 1'b0;
        while (pending_results.size() != 0)
            @(negedge i_clk);

        // second idling mode: slow sender
        src_idle_pct  = 73;
        sink_idle_pct = 24;
        run_random(110, 50, 0, 0);

        // no idling; the receiver holds off long while items keep coming,
        // so the result register fills and the block stalls its input
        src_idle_pct  = 0;
        sink_idle_pct = 0;
        hold_asked++;
        run_random(50, 60, 0, 0);
        run_random(80, 50, 0, 0);
        req_ch.valid = 1'b0;

        // drain, then wait on to catch anything extra
        drain_cycles = 0;
        while (pending_results.size() != 0 && drain_cycles < DRAIN_LIMIT) begin
            @(negedge i_clk);
            drain_cycles++;
        end
        repeat (8) @(negedge i_clk);
        if (pending_results.size() != 0) begin
            $error("%0d result items never arrived", pending_results.size());
            err_count++;
        end

        if (err_count == 0)
            $display("tb_double_ended_queue: done, clean");
        else
            $display("tb_double_ended_queue: done, errors");
        $finish;
    end

endmodule

// ----- sim.f -----
design/deq_pkg.sv
design/deq_if.sv
design/deq_ram.sv
design/deq_ctrl.sv
design/deq_dp.sv
design/double_ended_queue.sv
bench/tb_double_ended_queue.sv
